>>> src/polygon_bounding_parallelogram_defines.svh
// Assertion macros for the polygon bounding parallelogram block.
// Used by the top level, which supplies clk and rst_n in its own scope.
`ifndef POLYGON_BOUNDING_PARALLELOGRAM_DEFINES_SVH
`define POLYGON_BOUNDING_PARALLELOGRAM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PBP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define PBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> src/pbp_pkg.sv
// Package for the polygon bounding parallelogram block.
// Holds the fixed field widths, the back-end state type and the queue status.
`timescale 1ns / 1ps
package pbp_pkg;
  localparam int FIELD_W  = 16;
  localparam int BASE_W   = 36;
  localparam int HEIGHT_W = 16;
  localparam int SLANT_W  = 17;
  localparam int EXTENT_W = 16;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MUL,
    BK_DIV_LO,
    BK_DIV_HI,
    BK_SUB,
    BK_FIN
  } bk_state_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;
endpackage

>>> src/pbp_if.sv
// Channel interfaces for vertices in and results out.
// Depends on pbp_pkg for the field widths.
`timescale 1ns / 1ps
interface pbp_in_if;
  import pbp_pkg::*;
  logic valid;
  logic ready;
  logic signed [FIELD_W-1:0] vertex_x;
  logic signed [FIELD_W-1:0] vertex_y;
  logic last_vertex;
  modport source(output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink(input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pbp_out_if;
  import pbp_pkg::*;
  logic valid;
  logic ready;
  logic signed [BASE_W-1:0] base;
  logic [HEIGHT_W-1:0] height_out;
  logic signed [SLANT_W-1:0] slant;
  logic [EXTENT_W-1:0] extent_width;
  logic degenerate;
  modport source(output valid, base, height_out, slant, extent_width, degenerate,
                 input ready);
  modport sink(input valid, base, height_out, slant, extent_width, degenerate,
               output ready);
endinterface

>>> src/polygon_bounding_parallelogram.sv
// Top level of the polygon bounding parallelogram block.
// Depends on pbp_pkg, pbp_if, pbp_front, pbp_queue, pbp_back and the defines header.
`timescale 1ns / 1ps
`include "polygon_bounding_parallelogram_defines.svh"
// Usage:
// Vertices arrive on in_ch, one transfer per vertex, the final vertex of a
// polygon marked by last_vertex. One result per polygon leaves on out_ch.
// While a polygon loads, one vertex is taken every cycle while in_ch is not held
// off. Vertices beyond MAX_VERTICES are dropped, but a last_vertex mark on them
// still closes the polygon. After the last vertex the back end rescans the N
// stored vertices through the memory read port, during which in_ch is held off;
// in_ch is also held off while a job waits in the queue. The two extreme offsets
// then go through one shared divider that retires one quotient bit per cycle,
// then a subtract state and a finish state build the result. A polygon of zero
// height skips the rescan and division. Loading of the next polygon overlaps
// with the division of the previous one. Reset empties the job queue and the
// output register and starts a new polygon; the vertex store itself is not
// cleared. A stalled receiver holds the result in the output register and the
// back end waits, while the front keeps loading until its next polygon is queued.
module polygon_bounding_parallelogram #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pbp_in_if.sink     in_ch,
  pbp_out_if.source  out_ch
);
  import pbp_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int JW   = CNTW + 3*CW + 2;

  logic                 store_busy, back_scanning;
  logic [AW-1:0]        rd_addr;
  logic [2*CW-1:0]      rd_data;
  logic                 q_push, q_pop;
  q_stat_t              q_stat;
  logic [CNTW-1:0]      f_cnt, h_cnt;
  logic signed [CW:0]   f_width, f_slant, h_width, h_slant;
  logic [CW-1:0]        f_height, h_height;
  logic [JW-1:0]        q_wr_data, q_rd_data;

  assign store_busy = !q_stat.empty || back_scanning;
  assign q_wr_data  = {f_cnt, f_width, f_height, f_slant};
  assign {h_cnt, h_width, h_height, h_slant} = q_rd_data;

  pbp_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .store_busy (store_busy),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .job_push   (q_push),
    .job_cnt    (f_cnt),
    .job_width  (f_width),
    .job_height (f_height),
    .job_slant  (f_slant)
  );

  pbp_queue #(
    .W (JW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  pbp_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (!q_stat.empty),
    .job_pop    (q_pop),
    .job_cnt    (h_cnt),
    .job_width  (h_width),
    .job_height (h_height),
    .job_slant  (h_slant),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .scanning   (back_scanning),
    .out_ch     (out_ch)
  );

  `PBP_ASSERT_IMPL(a_push_not_full, q_push, !q_stat.full)
  `PBP_ASSERT_IMPL(a_no_load_in_scan, back_scanning, !(in_ch.valid && in_ch.ready))
  `PBP_ASSERT_NEXT(a_pop_starts_scan, q_pop && (h_height != '0), back_scanning)
  `PBP_ASSERT_IMPL(a_degenerate_rect, out_ch.valid && out_ch.degenerate, out_ch.slant == '0 && out_ch.height_out == '0)
endmodule

>>> src/pbp_front.sv
// Front end: accepts vertices, keeps the vertex store and the running extremes.
// Depends on pbp_pkg and pbp_in_if; issues one job per polygon.
`timescale 1ns / 1ps
module pbp_front #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  pbp_in_if.sink                                 in_ch,
  input  logic                                   store_busy,
  input  logic [$clog2(MAX_VERTICES)-1:0]        rd_addr,
  output logic [2*COORD_BITS-1:0]                rd_data,
  output logic                                   job_push,
  output logic [$clog2(MAX_VERTICES+1)-1:0]      job_cnt,
  output logic signed [COORD_BITS:0]             job_width,
  output logic [COORD_BITS-1:0]                  job_height,
  output logic signed [COORD_BITS:0]             job_slant
);
  import pbp_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int EW   = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

  logic [2*CW-1:0] mem [MAX_VERTICES];
  logic [2*CW-1:0] rd_data_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic signed [CW-1:0] min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  logic signed [CW-1:0] low_x_r, low_x_nxt, low_y_r, low_y_nxt;
  logic signed [CW-1:0] high_x_r, high_x_nxt, high_y_r, high_y_nxt;
  logic [EW-1:0] x_ext, y_ext;
  logic signed [CW-1:0] x_c, y_c;
  logic signed [CW:0] height_full;
  logic accept, room, store_en, first;

  assign in_ch.ready = !store_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign x_ext       = EW'(unsigned'(in_ch.vertex_x));
  assign y_ext       = EW'(unsigned'(in_ch.vertex_y));
  assign x_c         = signed'(x_ext[CW-1:0]);
  assign y_c         = signed'(y_ext[CW-1:0]);
  assign room        = cnt_r < CNTW'(MAX_VERTICES);
  assign store_en    = accept && room;
  assign first       = cnt_r == '0;

  always_comb begin
    cnt_nxt    = cnt_r;
    min_x_nxt  = min_x_r;
    max_x_nxt  = max_x_r;
    low_x_nxt  = low_x_r;
    low_y_nxt  = low_y_r;
    high_x_nxt = high_x_r;
    high_y_nxt = high_y_r;
    if (store_en) begin
      cnt_nxt = cnt_r + CNTW'(1);
      if (first) begin
        min_x_nxt  = x_c;
        max_x_nxt  = x_c;
        low_x_nxt  = x_c;
        low_y_nxt  = y_c;
        high_x_nxt = x_c;
        high_y_nxt = y_c;
      end else begin
        if (x_c < min_x_r) begin
          min_x_nxt = x_c;
        end
        if (x_c > max_x_r) begin
          max_x_nxt = x_c;
        end
        if (y_c < low_y_r) begin
          low_x_nxt = x_c;
          low_y_nxt = y_c;
        end
        if (y_c > high_y_r) begin
          high_x_nxt = x_c;
          high_y_nxt = y_c;
        end
      end
    end
    if (accept && in_ch.last_vertex) begin
      cnt_nxt = '0;
    end
  end

  assign job_push    = accept && in_ch.last_vertex;
  assign job_cnt     = cnt_r + CNTW'(store_en);
  assign job_width   = (CW+1)'(max_x_nxt) - (CW+1)'(min_x_nxt);
  assign height_full = (CW+1)'(high_y_nxt) - (CW+1)'(low_y_nxt);
  assign job_height  = height_full[CW-1:0];
  assign job_slant   = (CW+1)'(high_x_nxt) - (CW+1)'(low_x_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_x_r  <= min_x_nxt;
    max_x_r  <= max_x_nxt;
    low_x_r  <= low_x_nxt;
    low_y_r  <= low_y_nxt;
    high_x_r <= high_x_nxt;
    high_y_r <= high_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[cnt_r[AW-1:0]] <= {x_c, y_c};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

>>> src/pbp_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on pbp_pkg for the status struct.
`timescale 1ns / 1ps
module pbp_queue #(
  parameter int W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [W-1:0]     wr_data,
  input  logic             pop,
  output logic [W-1:0]     rd_data,
  output pbp_pkg::q_stat_t stat
);
  import pbp_pkg::*;

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;

  assign stat.empty = cnt_r == 2'd0;
  assign stat.full  = cnt_r == 2'd2;
  assign rd_data    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end
endmodule

>>> src/pbp_div.sv
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
// Standalone; the divisor is positive and held stable while busy.
`timescale 1ns / 1ps
module pbp_div #(
  parameter int NW   = 33,
  parameter int DENW = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [NW-1:0]   num,
  input  logic [DENW-1:0]        den,
  output logic                   done,
  output logic signed [NW-1:0]   quot
);
  localparam int QB = NW - 1;
  localparam int CB = $clog2(QB + 1);

  logic [QB-1:0]     num_r, quo_r;
  logic [DENW-1:0]   rem_r;
  logic [CB-1:0]     cnt_r;
  logic              busy_r, done_r, neg_r;
  logic [DENW:0]     tmp, diff;
  logic              ge;
  logic signed [NW-1:0] mag;

  assign mag  = num[NW-1] ? -num : num;
  assign tmp  = {rem_r, num_r[QB-1]};
  assign ge   = tmp >= {1'b0, den};
  assign diff = tmp - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CB'(QB);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CB'(1);
      if (cnt_r == CB'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= mag[QB-1:0];
      quo_r <= '0;
      rem_r <= '0;
      neg_r <= num[NW-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DENW-1:0] : tmp[DENW-1:0];
      num_r <= {num_r[QB-2:0], 1'b0};
      quo_r <= {quo_r[QB-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -signed'({1'b0, quo_r}) : signed'({1'b0, quo_r});
endmodule

>>> src/pbp_back.sv
// Back end: rescans the store along the spine normal, divides and builds the result.
// Depends on pbp_pkg, pbp_out_if and pbp_div.
`timescale 1ns / 1ps
module pbp_back #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   job_valid,
  output logic                                   job_pop,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]      job_cnt,
  input  logic signed [COORD_BITS:0]             job_width,
  input  logic [COORD_BITS-1:0]                  job_height,
  input  logic signed [COORD_BITS:0]             job_slant,
  output logic [$clog2(MAX_VERTICES)-1:0]        rd_addr,
  input  logic [2*COORD_BITS-1:0]                rd_data,
  output logic                                   scanning,
  pbp_out_if.source                              out_ch
);
  import pbp_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int DW   = 2*CW + 3;
  localparam int NW   = 2*CW + 1;
  localparam int LW   = NW + 1;
  localparam int BW   = LW + 1;

  bk_state_t state_r, state_nxt;

  logic [CNTW-1:0]        cnt_r, idx_r;
  logic signed [CW:0]     width_r, slant_r;
  logic [CW-1:0]          height_r;
  logic                   deg_r;
  logic                   s1_v_r, s1_first_r, s2_v_r, s2_first_r;
  logic signed [CW-1:0]   rd_x, rd_y, s2_x_r, s2_y_r;
  logic signed [DW-1:0]   px_r, py_r, d, lo_d_r, hi_d_r;
  logic signed [CW-1:0]   lo_x_r, lo_y_r, hi_x_r, hi_y_r;
  logic signed [CW:0]     h_s;
  logic signed [CW+1:0]   nsl;
  logic signed [NW-1:0]   nh_r, ql_r, qh_r, div_num, div_q;
  logic signed [LW-1:0]   left_r, right_r;
  logic signed [BW-1:0]   b, wide;
  logic                   take_par;
  logic                   issue, scan_done, div_start, div_done, out_load;

  logic                       out_valid_r;
  logic signed [BASE_W-1:0]   base_r;
  logic [HEIGHT_W-1:0]        height_o_r;
  logic signed [SLANT_W-1:0]  slant_o_r;
  logic [EXTENT_W-1:0]        width_o_r;
  logic                       deg_o_r;

  assign rd_x     = signed'(rd_data[2*CW-1:CW]);
  assign rd_y     = signed'(rd_data[CW-1:0]);
  assign h_s      = signed'({1'b0, height_r});
  assign nsl      = -((CW+2)'(slant_r));
  assign d        = px_r + py_r;
  assign b        = BW'(right_r) - BW'(left_r);
  assign wide     = BW'(width_r);
  assign take_par = b < wide;
  assign rd_addr  = idx_r[AW-1:0];
  assign div_num  = (state_r == BK_MUL) ? NW'(slant_r * lo_y_r) : nh_r;

  pbp_div #(
    .NW   (NW),
    .DENW (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (height_r),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          state_nxt = (job_height == '0) ? BK_FIN : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_done) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL:    state_nxt = BK_DIV_LO;
      BK_DIV_LO: begin
        if (div_done) begin
          state_nxt = BK_DIV_HI;
        end
      end
      BK_DIV_HI: begin
        if (div_done) begin
          state_nxt = BK_SUB;
        end
      end
      BK_SUB:    state_nxt = BK_FIN;
      BK_FIN: begin
        if (out_load) begin
          state_nxt = BK_IDLE;
        end
      end
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop   = 1'b0;
    issue     = 1'b0;
    scan_done = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    scanning  = 1'b0;
    unique case (state_r)
      BK_IDLE:   job_pop = job_valid;
      BK_SCAN: begin
        scanning  = 1'b1;
        issue     = idx_r < cnt_r;
        scan_done = (idx_r == cnt_r) && !s1_v_r && !s2_v_r;
      end
      BK_MUL:    div_start = 1'b1;
      BK_DIV_LO: div_start = div_done;
      BK_DIV_HI: div_start = 1'b0;
      BK_SUB:    div_start = 1'b0;
      BK_FIN:    out_load  = !out_valid_r || out_ch.ready;
      default:   job_pop   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      idx_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (job_pop) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + CNTW'(1);
      end
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cnt_r    <= job_cnt;
      width_r  <= job_width;
      height_r <= job_height;
      slant_r  <= job_slant;
      deg_r    <= job_height == '0;
    end
    if (issue) begin
      s1_first_r <= idx_r == '0;
    end
    if (s1_v_r) begin
      px_r       <= rd_x * h_s;
      py_r       <= rd_y * nsl;
      s2_x_r     <= rd_x;
      s2_y_r     <= rd_y;
      s2_first_r <= s1_first_r;
    end
    if (s2_v_r) begin
      if (s2_first_r || d < lo_d_r) begin
        lo_d_r <= d;
        lo_x_r <= s2_x_r;
        lo_y_r <= s2_y_r;
      end
      if (s2_first_r || d > hi_d_r) begin
        hi_d_r <= d;
        hi_x_r <= s2_x_r;
        hi_y_r <= s2_y_r;
      end
    end
    if (state_r == BK_MUL) begin
      nh_r <= slant_r * hi_y_r;
    end
    if (state_r == BK_DIV_LO && div_done) begin
      ql_r <= div_q;
    end
    if (state_r == BK_DIV_HI && div_done) begin
      qh_r <= div_q;
    end
    if (state_r == BK_SUB) begin
      left_r  <= LW'(lo_x_r) - LW'(ql_r);
      right_r <= LW'(hi_x_r) - LW'(qh_r);
    end
    if (out_load) begin
      base_r     <= (!deg_r && take_par) ? BASE_W'(b) : BASE_W'(width_r);
      slant_o_r  <= (!deg_r && take_par) ? SLANT_W'(slant_r) : '0;
      height_o_r <= HEIGHT_W'(height_r);
      width_o_r  <= EXTENT_W'(unsigned'(width_r));
      deg_o_r    <= deg_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.base         = base_r;
  assign out_ch.height_out   = height_o_r;
  assign out_ch.slant        = slant_o_r;
  assign out_ch.extent_width = width_o_r;
  assign out_ch.degenerate   = deg_o_r;
endmodule

>>> sim/polygon_bounding_parallelogram_tb.sv
// Self-checking testbench for polygon_bounding_parallelogram: random and directed
// polygons go in, every result is predicted in a tracker class and compared as one struct.
// Depends on pbp_pkg, the pbp_in_if and pbp_out_if interfaces and the block itself.
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [pbp_pkg::BASE_W-1:0]  base;
  logic [pbp_pkg::HEIGHT_W-1:0]       height;
  logic signed [pbp_pkg::SLANT_W-1:0] slant;
  logic [pbp_pkg::EXTENT_W-1:0]       width;
  logic                               degenerate;
} box_t;

class box_tracker;
  localparam int STORE_DEPTH = 64;

  box_t    expected_boxes[$];
  longint  store_x[STORE_DEPTH];
  longint  store_y[STORE_DEPTH];
  int      stored;
  longint  min_x;
  longint  max_x;
  int      low_idx;
  int      high_idx;
  int      mismatches;
  int      boxes_checked;
  int      degenerate_seen;
  int      slanted_seen;
  int      overflow_seen;

  // Loads one accepted vertex and, on the closing vertex, predicts the box.
  function void note_vertex(logic signed [15:0] vx, logic signed [15:0] vy, logic last);
    longint width, height, slant, proj, lo_d, hi_d, left, right, b;
    int lo, hi;
    box_t box;
    if (stored < STORE_DEPTH) begin
      store_x[stored] = vx;
      store_y[stored] = vy;
      if (stored == 0) begin
        min_x = vx;
        max_x = vx;
        low_idx = 0;
        high_idx = 0;
      end else begin
        if (vx < min_x) min_x = vx;
        if (vx > max_x) max_x = vx;
        if (vy < store_y[low_idx]) low_idx = stored;
        if (vy > store_y[high_idx]) high_idx = stored;
      end
      stored++;
    end else begin
      overflow_seen++;
    end
    if (!last) return;
    width = max_x - min_x;
    height = store_y[high_idx] - store_y[low_idx];
    slant = store_x[high_idx] - store_x[low_idx];
    box.base = width[35:0];
    box.slant = '0;
    box.degenerate = 1'b0;
    if (height == 0) begin
      box.degenerate = 1'b1;
      degenerate_seen++;
    end else begin
      lo = 0;
      hi = 0;
      lo_d = store_x[0] * height - store_y[0] * slant;
      hi_d = lo_d;
      for (int i = 1; i < stored; i++) begin
        proj = store_x[i] * height - store_y[i] * slant;
        if (proj < lo_d) begin
          lo_d = proj;
          lo = i;
        end
        if (proj > hi_d) begin
          hi_d = proj;
          hi = i;
        end
      end
      left = store_x[lo] - (slant * store_y[lo]) / height;
      right = store_x[hi] - (slant * store_y[hi]) / height;
      b = right - left;
      if (b < width) begin
        box.base = b[35:0];
        box.slant = slant[16:0];
        slanted_seen++;
      end
    end
    box.height = height[15:0];
    box.width = width[15:0];
    expected_boxes.push_back(box);
    stored = 0;
  endfunction

  function void check_box(box_t got);
    box_t want;
    boxes_checked++;
    if (expected_boxes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result transfer: base %0d", got.base);
      return;
    end
    want = expected_boxes.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"Mismatch: expected base %0d h %0d slant %0d w %0d deg %0b, ",
                  "got %0d %0d %0d %0d %0b"},
                 want.base, want.height, want.slant, want.width, want.degenerate,
                 got.base, got.height, got.slant, got.width, got.degenerate);
    end
  endfunction

  function int pending();
    return expected_boxes.size();
  endfunction
endclass

module polygon_bounding_parallelogram_tb;
  import pbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int TARGET_VERTICES = 1300;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  int   vertices_sent;
  int   polygons_sent;
  box_tracker tracker;
  box_t seen_box;

  pbp_in_if  in_ch ();
  pbp_out_if out_ch ();

  polygon_bounding_parallelogram i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_ch.valid && in_ch.ready) begin
        tracker.note_vertex(in_ch.vertex_x, in_ch.vertex_y, in_ch.last_vertex);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_box.base = out_ch.base;
        seen_box.height = out_ch.height_out;
        seen_box.slant = out_ch.slant;
        seen_box.width = out_ch.extent_width;
        seen_box.degenerate = out_ch.degenerate;
        tracker.check_box(seen_box);
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_vertex(logic signed [15:0] vx, logic signed [15:0] vy, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.vertex_x <= vx;
    in_ch.vertex_y <= vy;
    in_ch.last_vertex <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    vertices_sent++;
  endtask

  function automatic logic signed [15:0] pick_coord(int spread);
    case (spread)
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(40)) - 20);
      2: return $urandom_range(1) ? 16'(16'sh7fff - $urandom_range(3))
                                  : 16'(16'sh8000 + $urandom_range(3));
      default: return 16'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  task automatic send_polygon(int n, int spread);
    for (int i = 0; i < n; i++)
      send_vertex(pick_coord(spread), pick_coord(spread), i == n - 1);
    polygons_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    tracker = new();
    idle_pct = 0;
    stall_pct = 0;
    vertices_sent = 0;
    polygons_sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.vertex_x = '0;
    in_ch.vertex_y = '0;
    in_ch.last_vertex = 1'b0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A lone vertex, a flat pair and a tall triangle spanning the full range.
    send_vertex(16'sh7fff, 16'sh8000, 1'b1);
    send_vertex(16'sh8000, 16'sh0005, 1'b0);
    send_vertex(16'sh7fff, 16'sh0005, 1'b1);
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
    send_vertex(16'sh0000, 16'sh0000, 1'b1);
    polygons_sent += 3;
    // A slanted parallelogram with ties on the lowest and highest rows.
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd4, 16'sd0, 1'b0);
    send_vertex(16'sd14, 16'sd10, 1'b0);
    send_vertex(16'sd10, 16'sd10, 1'b1);
    send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh8000, 16'sh7fff, 1'b1);
    polygons_sent += 2;
    // Overfull polygon whose closing mark lands on a dropped vertex.
    send_polygon(66, 0);
    drain();

    while (vertices_sent < TARGET_VERTICES) begin
      case ((vertices_sent * 4) / TARGET_VERTICES)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      if ($urandom_range(29) == 0) n = 64 + $urandom_range(3);
      else if ($urandom_range(9) == 0) n = 1 + $urandom_range(2);
      else n = 3 + $urandom_range(10);
      send_polygon(n, $urandom_range(3));
    end
    drain();
    repeat (200) @(posedge clk);

    $display("Ran %0d polygons of %0d vertices; %0d results checked, %0d slanted, %0d flat.",
             polygons_sent, vertices_sent, tracker.boxes_checked, tracker.slanted_seen,
             tracker.degenerate_seen);
    $display("%0d vertices went past a full store; %0d mismatches.",
             tracker.overflow_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/pbp_pkg.sv
src/pbp_if.sv
src/pbp_front.sv
src/pbp_queue.sv
src/pbp_div.sv
src/pbp_back.sv
src/polygon_bounding_parallelogram.sv
sim/polygon_bounding_parallelogram_tb.sv
